@@ rtl/price_gap_zone_tracker_macros.svh @@
// assertion macros used by the tracker top level
`ifndef PRICE_GAP_ZONE_TRACKER_MACROS_SVH
`define PRICE_GAP_ZONE_TRACKER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PGZT_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("pgzt assertion failed");

// next-cycle implication
`define PGZT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("pgzt assertion failed");

`endif

@@ rtl/pgzt_pkg.sv @@
// shared types and constants of the price gap zone tracker
package pgzt_pkg;

    localparam int PRICE_W         = 32;
    localparam int MID_W           = PRICE_W + 1;
    localparam int CNT_W           = 7;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    localparam logic [7:0]  GAP_TICKS_RST   = 8'd10;
    localparam logic [15:0] TICK_SIZE_RST   = 16'd1;
    localparam logic [1:0]  SEARCH_MODE_RST = 2'd0;

    localparam logic [1:0] REG_GAP_TICKS   = 2'd0;
    localparam logic [1:0] REG_TICK_SIZE   = 2'd1;
    localparam logic [1:0] REG_SEARCH_MODE = 2'd2;

    localparam logic [1:0] MODE_CLOSEST = 2'd0;
    localparam logic [1:0] MODE_ABOVE   = 2'd1;
    localparam logic [1:0] MODE_BELOW   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_MATCH_END,
        S_INSERT,
        S_SCAN,
        S_SCAN_END,
        S_PICK
    } t_state;

    typedef struct packed {
        logic [PRICE_W-1:0] key;
        logic [PRICE_W-1:0] top;
        logic [PRICE_W-1:0] bottom;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic start;
        logic rd_en;
        logic rd_scan;
        logic ins_we;
        logic scan_init;
    } t_tbl_ctrl;

    typedef struct packed {
        logic               found;
        logic [PRICE_W-1:0] top;
        logic [PRICE_W-1:0] bottom;
        logic [MID_W-1:0]   middle;
        logic [CNT_W-1:0]   count;
        logic               overflow;
    } t_zone_res;

endpackage

@@ rtl/pgzt_if.sv @@
// bar input and result output channel interfaces
interface pgzt_bar_if import pgzt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic               new_day;

    modport source (output valid, bar_open, bar_high, bar_low, new_day, input ready);
    modport sink   (input valid, bar_open, bar_high, bar_low, new_day, output ready);
endinterface

interface pgzt_res_if import pgzt_pkg::*;;
    logic               valid;
    logic               ready;
    logic               up_found;
    logic [PRICE_W-1:0] up_top;
    logic [PRICE_W-1:0] up_bottom;
    logic [MID_W-1:0]   up_middle;
    logic               down_found;
    logic [PRICE_W-1:0] down_top;
    logic [PRICE_W-1:0] down_bottom;
    logic [MID_W-1:0]   down_middle;
    logic [CNT_W-1:0]   up_count;
    logic [CNT_W-1:0]   down_count;
    logic               table_overflow;

    modport source (output valid, up_found, up_top, up_bottom, up_middle, down_found,
                    down_top, down_bottom, down_middle, up_count, down_count,
                    table_overflow, input ready);
    modport sink   (input valid, up_found, up_top, up_bottom, up_middle, down_found,
                    down_top, down_bottom, down_middle, up_count, down_count,
                    table_overflow, output ready);
endinterface

@@ rtl/price_gap_zone_tracker.sv @@
// price gap zone tracker top level: apb registers, bar history, sequencer
//
//  port     | role   | moves
//  ---------+--------+----------------------------------------------
//  i_bar    | sink   | one price bar per transaction
//  o_res    | source | one result per bar (zones, counts, overflow)
//  apb      | slave  | gap_ticks, tick_size, search_mode registers
//
// a bar after warmup makes a key match pass and a removal/search pass over
// each table memory, one entry read per cycle on its single read port, plus
// an insert step and a result step.
// the first three bars after reset skip the table passes.
// valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// a stalled result holds the sequencer in its result cycle; a new bar is taken
// once the previous result is registered.
`include "price_gap_zone_tracker_macros.svh"

module price_gap_zone_tracker import pgzt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pgzt_bar_if.sink           i_bar,
    pgzt_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_addr;
    logic [7:0]         r_gap_ticks;
    logic [15:0]        r_tick_size;
    logic [1:0]         r_search_mode;
    logic [1:0]         r_warm;
    logic               r_cold;
    logic [PRICE_W-1:0] r_h1, r_h2, r_h3, r_l1, r_l2, r_l3;
    logic [PRICE_W-1:0] r_open, r_high, r_low;
    logic               r_out_valid;

    logic               accept;
    logic               load;
    logic               last;
    logic               warm;
    logic [1:0]         reg_idx;
    logic [23:0]        gap;
    logic               up_ok;
    logic               down_ok;
    t_entry             up_ins;
    t_entry             down_ins;
    t_tbl_ctrl          ctrl;
    t_zone_res          up_res;
    t_zone_res          down_res;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks   <= GAP_TICKS_RST;
            r_tick_size   <= TICK_SIZE_RST;
            r_search_mode <= SEARCH_MODE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_GAP_TICKS:   r_gap_ticks   <= pwdata[7:0];
                REG_TICK_SIZE:   r_tick_size   <= pwdata[15:0];
                REG_SEARCH_MODE: r_search_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAP_TICKS:   prdata = {24'd0, r_gap_ticks};
            REG_TICK_SIZE:   prdata = {16'd0, r_tick_size};
            REG_SEARCH_MODE: prdata = {30'd0, r_search_mode};
            default:         prdata = '0;
        endcase
    end

    // gap detection on the three-bar history
    assign gap     = r_gap_ticks * r_tick_size;
    assign up_ok   = (r_h3 < r_l1) && ((r_l1 - r_h3) >= {8'd0, gap});
    assign down_ok = (r_l3 > r_h1) && ((r_l3 - r_h1) >= {8'd0, gap});

    assign up_ins.key      = r_h1;
    assign up_ins.top      = r_l1;
    assign up_ins.bottom   = r_h3;
    assign down_ins.key    = r_l3;
    assign down_ins.top    = r_l3;
    assign down_ins.bottom = r_h1;

    // sequencer
    assign warm   = r_warm == 2'd3;
    assign accept = i_bar.valid && i_bar.ready;
    assign last   = r_addr == AW'(TABLE_DEPTH - 1);
    assign load   = (r_state == S_PICK) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = warm ? S_MATCH : S_PICK;
                end
            end
            S_MATCH:     if (last) n_state = S_MATCH_END;
            S_MATCH_END: n_state = S_INSERT;
            S_INSERT:    n_state = S_SCAN;
            S_SCAN:      if (last) n_state = S_SCAN_END;
            S_SCAN_END:  n_state = S_PICK;
            S_PICK:      if (load) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_bar.ready    = r_state == S_IDLE;
        ctrl.clear     = accept && warm && i_bar.new_day;
        ctrl.start     = accept;
        ctrl.rd_en     = (r_state == S_MATCH) || (r_state == S_SCAN);
        ctrl.rd_scan   = r_state == S_SCAN;
        ctrl.ins_we    = r_state == S_INSERT;
        ctrl.scan_init = r_state == S_INSERT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (ctrl.rd_en) begin
            r_addr <= last ? '0 : r_addr + 1'b1;
        end
    end

    // bar capture and history
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_open <= i_bar.bar_open;
            r_high <= i_bar.bar_high;
            r_low  <= i_bar.bar_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
            r_cold <= 1'b0;
            r_h1   <= '0;
            r_h2   <= '0;
            r_h3   <= '0;
            r_l1   <= '0;
            r_l2   <= '0;
            r_l3   <= '0;
        end else begin
            if (accept) begin
                r_cold <= !warm;
            end
            if (load) begin
                if (!warm) begin
                    r_warm <= r_warm + 1'b1;
                end
                r_h3 <= r_h2;
                r_h2 <= r_h1;
                r_h1 <= r_high;
                r_l3 <= r_l2;
                r_l2 <= r_l1;
                r_l1 <= r_low;
            end
        end
    end

    pgzt_table #(.DEPTH(TABLE_DEPTH)) u_up_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_addr       (r_addr),
        .i_ins_en     (up_ok),
        .i_ins        (up_ins),
        .i_kill_by_top(1'b0),
        .i_kill_price (r_low),
        .i_open       (r_open),
        .i_mode       (r_search_mode),
        .o_res        (up_res)
    );

    pgzt_table #(.DEPTH(TABLE_DEPTH)) u_down_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_addr       (r_addr),
        .i_ins_en     (down_ok),
        .i_ins        (down_ins),
        .i_kill_by_top(1'b1),
        .i_kill_price (r_high),
        .i_open       (r_open),
        .i_mode       (r_search_mode),
        .o_res        (down_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_cold) begin
                o_res.up_found       <= 1'b0;
                o_res.up_top         <= '0;
                o_res.up_bottom      <= '0;
                o_res.up_middle      <= '0;
                o_res.down_found     <= 1'b0;
                o_res.down_top       <= '0;
                o_res.down_bottom    <= '0;
                o_res.down_middle    <= '0;
                o_res.up_count       <= '0;
                o_res.down_count     <= '0;
                o_res.table_overflow <= 1'b0;
            end else begin
                o_res.up_found       <= up_res.found;
                o_res.up_top         <= up_res.top;
                o_res.up_bottom      <= up_res.bottom;
                o_res.up_middle      <= up_res.middle;
                o_res.down_found     <= down_res.found;
                o_res.down_top       <= down_res.top;
                o_res.down_bottom    <= down_res.bottom;
                o_res.down_middle    <= down_res.middle;
                o_res.up_count       <= up_res.count;
                o_res.down_count     <= down_res.count;
                o_res.table_overflow <= up_res.overflow || down_res.overflow;
            end
        end
    end

    assign o_res.valid = r_out_valid;

    `PGZT_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE)
    `PGZT_ASSERT_NEXT(a_cold_bar_skips_tables, accept && !warm, r_state == S_PICK)
    `PGZT_ASSERT_NEXT(a_stall_holds_pick, (r_state == S_PICK) && r_out_valid && !o_res.ready,
                      r_state == S_PICK)

endmodule

@@ rtl/pgzt_table.sv @@
// one zone table: entry memory, valid bits, insert, removal and search datapath
module pgzt_table import pgzt_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tbl_ctrl          i_ctrl,
    input  logic [AW-1:0]      i_addr,
    input  logic               i_ins_en,
    input  t_entry             i_ins,
    input  logic               i_kill_by_top,
    input  logic [PRICE_W-1:0] i_kill_price,
    input  logic [PRICE_W-1:0] i_open,
    input  logic [1:0]         i_mode,
    output t_zone_res          o_res
);

    localparam int CW = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    t_entry             r_rd;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic               r_rd_scan;
    logic [DEPTH-1:0]   r_valid;
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic               r_free;
    logic [AW-1:0]      r_free_idx;
    logic               r_ovf;
    logic               r_ab_f;
    t_entry             r_ab;
    logic               r_be_f;
    t_entry             r_be;
    logic [CW-1:0]      r_count;

    logic               wr_en;
    logic [AW-1:0]      wr_slot;
    logic               rd_live;
    logic               kill;
    logic               pick_ab;
    logic               found;
    t_entry             sel;
    logic [PRICE_W-1:0] dist_ab;
    logic [PRICE_W-1:0] dist_be;
    logic [CW+CNT_W-1:0] count_ext;

    assign wr_en   = i_ctrl.ins_we && i_ins_en && (r_hit || r_free);
    assign wr_slot = r_hit ? r_hit_idx : r_free_idx;
    assign rd_live = r_valid[r_rd_idx];
    assign kill    = i_kill_by_top ? (r_rd.top <= i_kill_price)
                                   : (r_rd.bottom >= i_kill_price);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot] <= i_ins;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // match pass runs before the insert and the scan pass after it, so no
    // read ever overlaps a write to the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_scan <= 1'b0;
            r_rd_idx  <= '0;
            r_valid   <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_ovf     <= 1'b0;
            r_ab_f    <= 1'b0;
            r_be_f    <= 1'b0;
            r_count   <= '0;
        end else begin
            r_rd_vld  <= i_ctrl.rd_en;
            r_rd_scan <= i_ctrl.rd_scan;
            r_rd_idx  <= i_addr;
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end
            if (i_ctrl.start) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_ovf  <= 1'b0;
            end
            if (r_rd_vld && !r_rd_scan) begin
                if (rd_live && r_rd.key == i_ins.key && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!rd_live && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            if (i_ctrl.ins_we && i_ins_en) begin
                if (wr_en) begin
                    r_valid[wr_slot] <= 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_ctrl.scan_init) begin
                r_ab_f  <= 1'b0;
                r_be_f  <= 1'b0;
                r_count <= '0;
            end
            if (r_rd_vld && r_rd_scan && rd_live) begin
                if (kill) begin
                    r_valid[r_rd_idx] <= 1'b0;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (r_rd.key >= i_open) begin
                        if (!r_ab_f || r_rd.key < r_ab.key) begin
                            r_ab_f <= 1'b1;
                            r_ab   <= r_rd;
                        end
                    end else begin
                        if (!r_be_f || r_rd.key > r_be.key) begin
                            r_be_f <= 1'b1;
                            r_be   <= r_rd;
                        end
                    end
                end
            end
        end
    end

    assign dist_ab = r_ab.key - i_open;
    assign dist_be = i_open - r_be.key;

    always_comb begin
        case (i_mode)
            MODE_ABOVE: pick_ab = 1'b1;
            MODE_BELOW: pick_ab = 1'b0;
            default: begin
                if (!r_ab_f) begin
                    pick_ab = 1'b0;
                end else if (!r_be_f) begin
                    pick_ab = 1'b1;
                end else begin
                    // equal distance goes to the zone below
                    pick_ab = dist_ab < dist_be;
                end
            end
        endcase
    end

    assign found     = pick_ab ? r_ab_f : r_be_f;
    assign sel       = pick_ab ? r_ab : r_be;
    assign count_ext = {{CNT_W{1'b0}}, r_count};

    always_comb begin
        o_res.found    = found;
        o_res.top      = found ? sel.top : '0;
        o_res.bottom   = found ? sel.bottom : '0;
        o_res.middle   = found ? ({1'b0, sel.top} + {1'b0, sel.bottom}) : '0;
        o_res.count    = count_ext[CNT_W-1:0];
        o_res.overflow = r_ovf;
    end

endmodule
